>>> sv/bos_pkg.sv
// Shared types and constants for the bounded ordered set.
// Used by bos_scan and bounded_ordered_set; no dependencies.
package bos_pkg;

    localparam int KeyBits   = 12;
    localparam int WordIdxW  = 6;
    localparam int WordBits  = 1 << WordIdxW;
    localparam int WordCount = 1 << (KeyBits - WordIdxW);
    localparam int WordAddrW = KeyBits - WordIdxW;
    localparam int OpW       = 3;
    localparam int StatusW   = 2;
    localparam int UnivW     = 4;

    localparam logic [UnivW-1:0] UnivReset = UnivW'(KeyBits);

    localparam logic [OpW-1:0] OP_INSERT = 3'd0;
    localparam logic [OpW-1:0] OP_DELETE = 3'd1;
    localparam logic [OpW-1:0] OP_FIND   = 3'd2;
    localparam logic [OpW-1:0] OP_SUCC   = 3'd3;
    localparam logic [OpW-1:0] OP_PRED   = 3'd4;
    localparam logic [OpW-1:0] OP_MIN    = 3'd5;
    localparam logic [OpW-1:0] OP_MAX    = 3'd6;

    localparam logic [StatusW-1:0] ST_OK    = 2'd0;
    localparam logic [StatusW-1:0] ST_NONE  = 2'd1;
    localparam logic [StatusW-1:0] ST_RANGE = 2'd2;

    // Result of a bit search over one 64-bit word
    typedef struct packed {
        logic                any;
        logic [WordIdxW-1:0] lo;
        logic [WordIdxW-1:0] hi;
    } t_scan;

endpackage

>>> sv/bounded_ordered_set.sv
// Top level of the bounded ordered set: command FSM, summary word, leaf RAM.
// Depends on bos_pkg, bos_ram, bos_scan.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------
//  command  | in        | i_in_valid / o_in_stall | i_opcode, i_key
//  result   | out       | o_out_valid/ i_out_stall| o_status, o_value
//  config   | in        | i_cfg_valid/ o_cfg_ready| i_cfg_data (universe_bits)
//
// One command at a time, in the steps accept, dispatch (leaf read issued),
// leaf (search / write back) and result load. Successor or predecessor
// that has to leave the first leaf word takes a second leaf read; min and
// max go from dispatch straight to that read. The leaf RAM has one read port.
// Reset (synchronous, active low) empties the set at once: the summary word
// is cleared, and a leaf word whose summary bit is clear reads as zero.
// A stalled result sits in the output register; the next command is still
// taken and runs up to its own result load.
module bounded_ordered_set (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [bos_pkg::OpW-1:0]      i_opcode,
    input  logic [bos_pkg::KeyBits-1:0]  i_key,
    // result
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [bos_pkg::StatusW-1:0]  o_status,
    output logic [bos_pkg::KeyBits-1:0]  o_value,
    // configuration
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bos_pkg::UnivW-1:0]    i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DISPATCH = 5'b00010,
        S_LEAF     = 5'b00100,
        S_LEAF2    = 5'b01000,
        S_DONE     = 5'b10000
    } t_state;

    localparam int WB = bos_pkg::WordBits;
    localparam int AW = bos_pkg::WordAddrW;
    localparam int IW = bos_pkg::WordIdxW;
    localparam int KB = bos_pkg::KeyBits;
    localparam int SW = bos_pkg::StatusW;

    t_state r_state, n_state;

    logic [bos_pkg::OpW-1:0]   r_op;
    logic [KB-1:0]             r_key;
    logic [AW-1:0]             r_word, n_word;
    logic [IW-1:0]             r_pos, n_pos;
    logic [WB-1:0]             r_sum, n_sum;
    logic [bos_pkg::UnivW-1:0] r_univ;
    logic [SW-1:0]             r_res_status, n_res_status;
    logic [KB-1:0]             r_res_value, n_res_value;
    logic                      r_out_valid, n_out_valid;
    logic [SW-1:0]             r_out_status;
    logic [KB-1:0]             r_out_value;

    // leaf RAM port signals
    logic          ram_wr_en;
    logic [WB-1:0] ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [WB-1:0] ram_rd_data;

    logic [WB-1:0]  leaf;
    logic [WB-1:0]  leaf_scan_in;
    logic [WB-1:0]  sum_scan_in;
    bos_pkg::t_scan leaf_scan;
    bos_pkg::t_scan sum_scan;

    logic [IW-1:0]  eff;
    logic           key_bad;
    logic           in_xfer;
    logic           out_free;

    bos_ram #(
        .WIDTH(WB),
        .DEPTH(bos_pkg::WordCount)
    ) u_leaf_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_word),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    bos_scan u_leaf_scan (
        .i_word (leaf_scan_in),
        .o_scan (leaf_scan)
    );

    bos_scan u_sum_scan (
        .i_word (sum_scan_in),
        .o_scan (sum_scan)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_value     = r_out_value;

    // A leaf word never written since reset has a clear summary bit;
    // a clear summary bit always means an all-zero word.
    assign leaf = r_sum[r_word] ? ram_rd_data : '0;

    // Effective universe: register clamped to 1..KeyBits
    always_comb begin
        if (r_univ == '0) begin
            eff = IW'(1);
        end else if (r_univ > bos_pkg::UnivW'(KB)) begin
            eff = IW'(KB);
        end else begin
            eff = IW'(r_univ);
        end
    end
    assign key_bad = ((r_key >> eff) != '0);

    // Search inputs: leaf bits at/after pos for successor, at/before pos for
    // predecessor, whole word on the second read. Summary: whole word for
    // min/max, words above or below the current one after a leaf miss.
    always_comb begin
        if (r_state == S_LEAF && r_op == bos_pkg::OP_SUCC) begin
            leaf_scan_in = leaf & ({WB{1'b1}} << r_pos);
        end else if (r_state == S_LEAF && r_op == bos_pkg::OP_PRED) begin
            leaf_scan_in = leaf & ({WB{1'b1}} >> (IW'(WB - 1) - r_pos));
        end else begin
            leaf_scan_in = leaf;
        end
        if (r_state == S_LEAF && r_op == bos_pkg::OP_SUCC) begin
            sum_scan_in = r_sum & (({WB{1'b1}} << r_word) << 1);
        end else if (r_state == S_LEAF && r_op == bos_pkg::OP_PRED) begin
            sum_scan_in = r_sum & ((WB'(1) << r_word) - WB'(1));
        end else begin
            sum_scan_in = r_sum;
        end
    end

    always_comb begin
        logic [KB-1:0] p;
        logic [WB-1:0] upd;
        n_state      = r_state;
        n_word       = r_word;
        n_pos        = r_pos;
        n_sum        = r_sum;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        ram_wr_en    = 1'b0;
        ram_wr_data  = leaf;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_word;
        p            = r_key;
        upd          = leaf;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                n_res_status = bos_pkg::ST_NONE;
                n_res_value  = '0;
                if (key_bad && r_op <= bos_pkg::OP_PRED) begin
                    n_res_status = bos_pkg::ST_RANGE;
                    n_state      = S_DONE;
                end else begin
                    case (r_op)
                        bos_pkg::OP_INSERT, bos_pkg::OP_DELETE, bos_pkg::OP_FIND: begin
                            p = r_key;
                        end
                        bos_pkg::OP_SUCC: begin
                            p = r_key + KB'(1);
                        end
                        bos_pkg::OP_PRED: begin
                            p = r_key - KB'(1);
                        end
                        default: begin
                            p = r_key;
                        end
                    endcase
                    n_word      = p[KB-1:IW];
                    n_pos       = p[IW-1:0];
                    ram_rd_addr = p[KB-1:IW];
                    case (r_op)
                        bos_pkg::OP_INSERT, bos_pkg::OP_DELETE, bos_pkg::OP_FIND: begin
                            ram_rd_en = 1'b1;
                            n_state   = S_LEAF;
                        end
                        bos_pkg::OP_SUCC: begin
                            // no key above the top of the full universe
                            if (r_key == {KB{1'b1}}) begin
                                n_state = S_DONE;
                            end else begin
                                ram_rd_en = 1'b1;
                                n_state   = S_LEAF;
                            end
                        end
                        bos_pkg::OP_PRED: begin
                            if (r_key == '0) begin
                                n_state = S_DONE;
                            end else begin
                                ram_rd_en = 1'b1;
                                n_state   = S_LEAF;
                            end
                        end
                        bos_pkg::OP_MIN, bos_pkg::OP_MAX: begin
                            if (!sum_scan.any) begin
                                n_state = S_DONE;
                            end else begin
                                n_word      = (r_op == bos_pkg::OP_MIN) ? sum_scan.lo
                                                                        : sum_scan.hi;
                                ram_rd_addr = n_word;
                                ram_rd_en   = 1'b1;
                                n_state     = S_LEAF2;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_LEAF: begin
                n_state      = S_DONE;
                n_res_status = bos_pkg::ST_NONE;
                n_res_value  = '0;
                case (r_op)
                    bos_pkg::OP_INSERT: begin
                        if (!leaf[r_pos]) begin
                            upd           = leaf | (WB'(1) << r_pos);
                            ram_wr_en     = 1'b1;
                            ram_wr_data   = upd;
                            n_sum[r_word] = 1'b1;
                            n_res_status  = bos_pkg::ST_OK;
                        end
                    end
                    bos_pkg::OP_DELETE: begin
                        if (leaf[r_pos]) begin
                            upd          = leaf & ~(WB'(1) << r_pos);
                            ram_wr_en    = 1'b1;
                            ram_wr_data  = upd;
                            n_res_status = bos_pkg::ST_OK;
                            if (upd == '0) begin
                                n_sum[r_word] = 1'b0;
                            end
                        end
                    end
                    bos_pkg::OP_FIND: begin
                        if (leaf[r_pos]) begin
                            n_res_status = bos_pkg::ST_OK;
                        end
                    end
                    bos_pkg::OP_SUCC, bos_pkg::OP_PRED: begin
                        if (leaf_scan.any) begin
                            n_res_status = bos_pkg::ST_OK;
                            n_res_value  = {r_word, (r_op == bos_pkg::OP_SUCC) ?
                                            leaf_scan.lo : leaf_scan.hi};
                        end else if (sum_scan.any) begin
                            // next non-empty word in the search direction
                            n_word      = (r_op == bos_pkg::OP_SUCC) ? sum_scan.lo
                                                                     : sum_scan.hi;
                            ram_rd_addr = n_word;
                            ram_rd_en   = 1'b1;
                            n_state     = S_LEAF2;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_LEAF2: begin
                // word known non-empty from the summary
                n_res_status = bos_pkg::ST_OK;
                if (r_op == bos_pkg::OP_SUCC || r_op == bos_pkg::OP_MIN) begin
                    n_res_value = {r_word, leaf_scan.lo};
                end else begin
                    n_res_value = {r_word, leaf_scan.hi};
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = (r_out_valid && i_out_stall) || (r_state == S_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_univ      <= bos_pkg::UnivReset;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_univ <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op  <= i_opcode;
            r_key <= i_key;
        end
        r_word       <= n_word;
        r_pos        <= n_pos;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        if (r_state == S_DONE && out_free) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
        end
    end

endmodule

>>> sv/bos_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module bos_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/bos_scan.sv
// Lowest and highest set bit of one 64-bit word, binary search in six steps.
// Depends on bos_pkg.
module bos_scan (
    input  logic [bos_pkg::WordBits-1:0] i_word,
    output bos_pkg::t_scan               o_scan
);

    always_comb begin
        logic [bos_pkg::WordBits-1:0] v_lo;
        logic [bos_pkg::WordBits-1:0] v_hi;
        logic [bos_pkg::WordBits-1:0] half_mask;
        logic [bos_pkg::WordIdxW-1:0] idx_lo;
        logic [bos_pkg::WordIdxW-1:0] idx_hi;
        v_lo   = i_word;
        v_hi   = i_word;
        idx_lo = '0;
        idx_hi = '0;
        for (int l = bos_pkg::WordIdxW - 1; l >= 0; l--) begin
            half_mask = (bos_pkg::WordBits'(1) << (1 << l)) - bos_pkg::WordBits'(1);
            // lowest: skip the lower half when it is empty
            if ((v_lo & half_mask) == '0) begin
                idx_lo[l] = 1'b1;
                v_lo      = v_lo >> (1 << l);
            end
            // highest: take the upper half when it holds anything
            if ((v_hi >> (1 << l)) != '0) begin
                idx_hi[l] = 1'b1;
                v_hi      = v_hi >> (1 << l);
            end
        end
        o_scan.any = (i_word != '0);
        o_scan.lo  = idx_lo;
        o_scan.hi  = idx_hi;
    end

endmodule

>>> sim/bounded_ordered_set_test.sv
// Self-checking testbench for bounded_ordered_set: random and directed set commands,
// universe register changes, and a bit-level model of the key set as scoreboard.
// Depends on bos_pkg and the bounded_ordered_set RTL.
module bounded_ordered_set_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KeyCount   = 1 << bos_pkg::KeyBits;
    localparam int MaxGap     = 14;
    localparam int PhaseItems = 250;
    localparam logic [bos_pkg::OpW-1:0] OP_UNUSED = 3'd7;

    // Expected results plus a flat bitmap of the members. The leaf/summary split
    // of the RTL is invisible from outside, so one bit per key is enough here.
    class ordered_set_scoreboard;
        typedef struct {
            logic [bos_pkg::StatusW-1:0] status;
            logic [bos_pkg::KeyBits-1:0] value;
        } t_set_result;

        t_set_result             pending_results[$];
        bit [KeyCount-1:0]       member_bits;
        int unsigned             universe_bits;
        int unsigned             mismatches;
        int unsigned             checked;

        function new();
            member_bits   = '0;
            universe_bits = 32'(bos_pkg::UnivReset);
            mismatches    = 0;
            checked       = 0;
        endfunction

        function void set_universe(logic [bos_pkg::UnivW-1:0] bits);
            universe_bits = 32'(bits);
        endfunction

        // Register value clamped to 1..KeyBits, turned into the key bound
        function int key_limit();
            int eff;
            eff = universe_bits;
            if (eff < 1) eff = 1;
            if (eff > bos_pkg::KeyBits) eff = bos_pkg::KeyBits;
            return 1 << eff;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Work out the result of one accepted command and update the set
        function void note_command(logic [bos_pkg::OpW-1:0] op,
                                   logic [bos_pkg::KeyBits-1:0] key);
            t_set_result r;
            int k;
            int found;
            int key_i;
            key_i    = 32'(key);
            found    = -1;
            r.status = bos_pkg::ST_NONE;
            r.value  = '0;
            if (op <= bos_pkg::OP_PRED && key_i >= key_limit()) begin
                r.status = bos_pkg::ST_RANGE;
            end else begin
                case (op)
                    bos_pkg::OP_INSERT: begin
                        if (!member_bits[key_i]) begin
                            member_bits[key_i] = 1'b1;
                            r.status = bos_pkg::ST_OK;
                        end
                    end
                    bos_pkg::OP_DELETE: begin
                        if (member_bits[key_i]) begin
                            member_bits[key_i] = 1'b0;
                            r.status = bos_pkg::ST_OK;
                        end
                    end
                    bos_pkg::OP_FIND: begin
                        if (member_bits[key_i]) r.status = bos_pkg::ST_OK;
                    end
                    bos_pkg::OP_SUCC: begin
                        for (k = key_i + 1; k < KeyCount && found < 0; k++)
                            if (member_bits[k]) found = k;
                    end
                    bos_pkg::OP_PRED: begin
                        for (k = key_i - 1; k >= 0 && found < 0; k--)
                            if (member_bits[k]) found = k;
                    end
                    bos_pkg::OP_MIN: begin
                        for (k = 0; k < KeyCount && found < 0; k++)
                            if (member_bits[k]) found = k;
                    end
                    bos_pkg::OP_MAX: begin
                        for (k = KeyCount - 1; k >= 0 && found < 0; k--)
                            if (member_bits[k]) found = k;
                    end
                    default: ;
                endcase
                // searches (and only searches) report a key
                if (found >= 0) begin
                    r.status = bos_pkg::ST_OK;
                    r.value  = found[bos_pkg::KeyBits-1:0];
                end
            end
            pending_results.push_back(r);
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic [bos_pkg::StatusW-1:0] status,
                          logic [bos_pkg::KeyBits-1:0] value);
            t_set_result e;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result status %0d value %0d", status, value));
            end else begin
                e = pending_results.pop_front();
                if (status !== e.status)
                    report($sformatf("result %0d: status %0d, expected %0d",
                                     checked, status, e.status));
                if (value !== e.value)
                    report($sformatf("result %0d: value %0d, expected %0d",
                                     checked, value, e.value));
            end
            checked++;
        endtask
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic [bos_pkg::OpW-1:0]      i_opcode;
    logic [bos_pkg::KeyBits-1:0]  i_key;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic [bos_pkg::StatusW-1:0]  o_status;
    logic [bos_pkg::KeyBits-1:0]  o_value;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [bos_pkg::UnivW-1:0]    i_cfg_data;

    ordered_set_scoreboard sb = new();

    // gap-free stretches on both sides
    bit          tx_quiet;
    bit          rx_quiet;
    int unsigned commands_sent;
    int unsigned settings_used;

    bounded_ordered_set i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_key       (i_key),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_value     (o_value),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Result side: random stall before every result, none in quiet stretches.
    initial begin
        int n;
        i_out_stall <= 1'b0;
        forever begin
            n = rx_quiet ? 0 : $urandom_range(0, MaxGap);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Result transfer: values seen at the edge are the pre-edge ones
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_status, o_value);
    end

    // One command transfer. valid stays high across back-to-back commands so it
    // never gets two assignments in one step.
    task send_cmd(input logic [bos_pkg::OpW-1:0] op,
                  input logic [bos_pkg::KeyBits-1:0] key);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MaxGap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_key      <= key;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_command(op, key);
        commands_sent++;
    endtask

    // Stop sending and let every outstanding result arrive, plus the latency
    task drain;
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Only called with the block idle
    task write_universe(input logic [bos_pkg::UnivW-1:0] bits);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= bits;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_universe(bits);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Random commands under one universe setting. Keys mostly stay in range and
    // nearly half of them crowd around a base so inserts, deletes and searches meet.
    task run_phase(input logic [bos_pkg::UnivW-1:0] bits);
        int i;
        int sel;
        int limit;
        int base;
        logic [bos_pkg::OpW-1:0]     op;
        logic [bos_pkg::KeyBits-1:0] key;
        drain();
        write_universe(bits);
        limit = sb.key_limit();
        base  = $urandom_range(0, limit - 1);
        for (i = 0; i < PhaseItems; i++) begin
            tx_quiet = (i >= 100 && i < 140);
            rx_quiet = (i >= 120 && i < 160);
            sel = $urandom_range(0, 99);
            if (sel < 30)      op = bos_pkg::OP_INSERT;
            else if (sel < 50) op = bos_pkg::OP_DELETE;
            else if (sel < 63) op = bos_pkg::OP_FIND;
            else if (sel < 76) op = bos_pkg::OP_SUCC;
            else if (sel < 89) op = bos_pkg::OP_PRED;
            else if (sel < 93) op = bos_pkg::OP_MIN;
            else if (sel < 97) op = bos_pkg::OP_MAX;
            else               op = OP_UNUSED;
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                key = bos_pkg::KeyBits'($urandom);
            end else if (sel < 55) begin
                key = bos_pkg::KeyBits'((base + $urandom_range(0, 191)) % limit);
            end else begin
                key = bos_pkg::KeyBits'($urandom_range(0, limit - 1));
            end
            send_cmd(op, key);
            // hold off once per phase until the block has handed back everything
            if (i == PhaseItems / 2) drain();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_opcode      <= bos_pkg::OP_INSERT;
        i_key         <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= bos_pkg::UnivReset;
        tx_quiet      = 1'b0;
        rx_quiet      = 1'b0;
        commands_sent = 0;
        settings_used = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty set, both ends of the key space, word boundary,
        // already present / not present, unused opcode, ignored key on min/max.
        send_cmd(bos_pkg::OP_MIN,    12'hfff);
        send_cmd(bos_pkg::OP_MAX,    12'h000);
        send_cmd(bos_pkg::OP_SUCC,   12'h000);
        send_cmd(bos_pkg::OP_PRED,   12'hfff);
        send_cmd(bos_pkg::OP_DELETE, 12'h000);
        send_cmd(bos_pkg::OP_INSERT, 12'h000);
        send_cmd(bos_pkg::OP_INSERT, 12'hfff);
        send_cmd(bos_pkg::OP_INSERT, 12'h000);
        send_cmd(bos_pkg::OP_FIND,   12'hfff);
        send_cmd(bos_pkg::OP_SUCC,   12'h000);
        send_cmd(bos_pkg::OP_PRED,   12'hfff);
        send_cmd(bos_pkg::OP_PRED,   12'h000);
        send_cmd(bos_pkg::OP_SUCC,   12'hfff);
        send_cmd(OP_UNUSED,          12'hfff);
        send_cmd(bos_pkg::OP_INSERT, 12'd63);
        send_cmd(bos_pkg::OP_INSERT, 12'd64);
        send_cmd(bos_pkg::OP_SUCC,   12'd63);
        send_cmd(bos_pkg::OP_PRED,   12'd64);
        send_cmd(bos_pkg::OP_DELETE, 12'hfff);
        send_cmd(bos_pkg::OP_MAX,    12'h000);

        // Shrunk universe: members above the bound stay visible to searches
        drain();
        write_universe(4'd1);
        send_cmd(bos_pkg::OP_INSERT, 12'd2);
        send_cmd(bos_pkg::OP_INSERT, 12'd1);
        send_cmd(bos_pkg::OP_SUCC,   12'd1);
        send_cmd(bos_pkg::OP_FIND,   12'd64);
        send_cmd(bos_pkg::OP_MAX,    12'hfff);

        run_phase(4'd12);
        run_phase(4'd0);
        run_phase(4'd15);
        run_phase(4'd1);
        run_phase(4'd5);
        run_phase(4'd13);
        run_phase(4'd9);
        run_phase(bos_pkg::UnivW'($urandom_range(2, 11)));

        drain();
        $display("Covered %0d commands over %0d universe settings, %0d results checked.",
                 commands_sent, settings_used, sb.checked);
        $display("Mismatches: %0d, results still outstanding: %0d.",
                 sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("bounded_ordered_set test passed");
        end else begin
            $display("bounded_ordered_set test failed");
        end
        $finish;
    end

    // Watchdog: the slowest legal run ends well before this timeout
    initial begin
        #10_000_000;
        $display("Timeout with %0d results outstanding.", sb.pending());
        $display("bounded_ordered_set test failed");
        $finish;
    end

endmodule

>>> sim.f
sv/bos_pkg.sv
sv/bos_ram.sv
sv/bos_scan.sv
sv/bounded_ordered_set.sv
sim/bounded_ordered_set_test.sv
